// File: rtl/core/lgrs_pkg.sv
// Shared types and constants for the Life generation row stencil core.
// No dependencies; imported by every module of the core.
`default_nettype none

package lgrs_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int COL_W       = 7;
    localparam logic [COL_W-1:0] COLS_RESET = 7'd50;
    localparam int QDEPTH      = 2;

    // one column's masked bits, passed to both neighbors
    typedef struct packed {
        logic above;
        logic held;
        logic down;
    } t_col_bits;

    // row control shared by all cells
    typedef struct packed {
        logic load;
        logic clear;
        logic flush;
    } t_cell_ctrl;

    typedef struct packed {
        logic [MAX_COLUMNS-1:0] next_cells;
        logic                   frame_end;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/lgrs_cell.sv
// One board column: holds its bits of the two previous rows and computes
// its next-generation bit from its own and both neighbors' bits. Uses lgrs_pkg.
`default_nettype none

module lgrs_cell
    import lgrs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cell_ctrl i_ctrl,
    input  wire logic       i_live,
    input  wire logic       i_down,
    input  wire t_col_bits  i_left,
    input  wire t_col_bits  i_right,
    output t_col_bits       o_col,
    output logic            o_next
);

    logic r_above;
    logic r_held;
    logic n_above;
    logic n_held;
    logic [3:0] w_sum;

    always_comb begin
        o_col.above = r_above & i_live;
        o_col.held  = r_held & i_live;
        o_col.down  = i_down & i_live & ~i_ctrl.flush;
    end

    assign w_sum = 4'(i_left.above) + 4'(i_left.held) + 4'(i_left.down)
                 + 4'(o_col.above) + 4'(o_col.down)
                 + 4'(i_right.above) + 4'(i_right.held) + 4'(i_right.down);

    assign o_next = i_live & ((w_sum == 4'd3) | (o_col.held & (w_sum == 4'd2)));

    always_comb begin
        n_above = r_above;
        n_held  = r_held;
        if (i_ctrl.clear) begin
            n_above = 1'b0;
            n_held  = 1'b0;
        end else if (i_ctrl.load) begin
            n_above = r_held;
            n_held  = i_down;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above <= 1'b0;
            r_held  <= 1'b0;
        end else begin
            r_above <= n_above;
            r_held  <= n_held;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/lgrs_ctrl.sv
// Row sequencing: input handshake, held-row flag and the extra flush beat
// after the last row of a frame. Uses lgrs_pkg.
`default_nettype none

module lgrs_ctrl
    import lgrs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire logic i_last,
    input  wire logic i_room,
    output logic      o_ready,
    output t_cell_ctrl o_ctrl,
    output logic      o_push,
    output logic      o_frame_end
);

    logic r_have;
    logic r_flush;
    logic n_have;
    logic n_flush;
    logic w_acc;
    logic w_flush_go;

    assign o_ready    = ~r_flush & i_room;
    assign w_acc      = i_valid & o_ready;
    assign w_flush_go = r_flush & i_room;

    always_comb begin
        o_ctrl.load  = w_acc;
        o_ctrl.clear = w_flush_go;
        o_ctrl.flush = r_flush;
    end

    assign o_push      = (w_acc & r_have) | w_flush_go;
    assign o_frame_end = r_flush;

    always_comb begin
        n_have  = r_have;
        n_flush = r_flush;
        if (w_flush_go) begin
            n_have  = 1'b0;
            n_flush = 1'b0;
        end else if (w_acc) begin
            n_have  = 1'b1;
            n_flush = i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have  <= 1'b0;
            r_flush <= 1'b0;
        end else begin
            r_have  <= n_have;
            r_flush <= n_flush;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/lgrs_outq.sv
// Two-beat result queue between the cell row and the output stream.
// Uses lgrs_pkg.
`default_nettype none

module lgrs_outq
    import lgrs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    input  wire logic    i_pop_ready,
    output logic         o_valid,
    output t_result      o_data,
    output logic         o_room
);

    t_result r_mem [QDEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;
    logic       w_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign o_room  = (r_cnt < 2'(QDEPTH));
    assign w_pop   = o_valid & i_pop_ready;

    always_comb begin
        n_wp  = i_push ? ~r_wp : r_wp;
        n_rp  = w_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt;
        if (i_push & ~w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_pop & ~i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/life_generation_row_stencil_core.sv
// One Conway B3/S23 generation over a streamed board, one row per beat.
// A row's result is computed when the row below it is accepted and is registered
// in the output queue; the last row's own result is pushed by the frame's flush beat.
// Throughput: one row per cycle while the queue has room, plus a flush beat per frame.
// Reset (sync, active low): rows cleared, queue empty, width back to 50.
// Depends on lgrs_pkg, lgrs_cell, lgrs_ctrl, lgrs_outq.
`default_nettype none

module life_generation_row_stencil_core
    import lgrs_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [COL_W-1:0]       i_cfg_data,     // columns_in_use
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [MAX_COLUMNS-1:0] s_axis_tdata,   // row_cells
    input  wire logic                   s_axis_tlast,   // last_row
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [MAX_COLUMNS-1:0]      m_axis_tdata,   // next_cells
    output logic                        m_axis_tlast    // frame_end
);

    logic [COL_W-1:0]       r_cols;
    logic [MAX_COLUMNS-1:0] w_live;
    logic [MAX_COLUMNS-1:0] w_next;
    t_col_bits              w_col [MAX_COLUMNS];
    t_cell_ctrl             w_ctrl;
    logic                   w_push;
    logic                   w_frame_end;
    logic                   w_room;
    t_result                w_res;
    t_result                w_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RESET;
        end else if (i_cfg_valid) begin
            r_cols <= i_cfg_data;
        end
    end

    lgrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_last      (s_axis_tlast),
        .i_room      (w_room),
        .o_ready     (s_axis_tready),
        .o_ctrl      (w_ctrl),
        .o_push      (w_push),
        .o_frame_end (w_frame_end)
    );

    for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_col
        localparam logic [COL_W-1:0] CIDX = COL_W'(c);
        t_col_bits w_left;
        t_col_bits w_right;

        assign w_live[c] = (CIDX < r_cols);

        if (c == 0) begin : g_lo
            assign w_left = '0;
        end else begin : g_lo
            assign w_left = w_col[c-1];
        end

        if (c == MAX_COLUMNS-1) begin : g_hi
            assign w_right = '0;
        end else begin : g_hi
            assign w_right = w_col[c+1];
        end

        lgrs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_live  (w_live[c]),
            .i_down  (s_axis_tdata[c]),
            .i_left  (w_left),
            .i_right (w_right),
            .o_col   (w_col[c]),
            .o_next  (w_next[c])
        );
    end

    always_comb begin
        w_res.next_cells = w_next;
        w_res.frame_end  = w_frame_end;
    end

    lgrs_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_data      (w_res),
        .i_pop_ready (m_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_data      (w_out),
        .o_room      (w_room)
    );

    assign m_axis_tdata = w_out.next_cells;
    assign m_axis_tlast = w_out.frame_end;

endmodule

`default_nettype wire
